// File: design/iubw_pkg.sv
// Shared types and constants of the integer upscale blit writer.
package iubw_pkg;

  // Field widths of the channels.
  localparam int DIM_W     = 12;
  localparam int ADDR_W    = 24;
  localparam int PIX_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_W     = 2 * DIM_W;
  // Address arithmetic carries two spare bits so clipping sees overflow past the buffer.
  localparam int AEXT_W    = ADDR_W + 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd4;

  // Register values after reset.
  localparam logic [DIM_W-1:0] RST_DEST_WIDTH  = 12'd1280;
  localparam logic [DIM_W-1:0] RST_DEST_HEIGHT = 12'd720;
  localparam logic [DIM_W-1:0] RST_SRC_WIDTH   = 12'd320;
  localparam logic [DIM_W-1:0] RST_SRC_HEIGHT  = 12'd240;

  localparam logic FMT_RGB565 = 1'b0;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SCALE_STEP,
    OP_OFFSET,
    OP_MUL_LEAD,
    OP_LEAD_SUM,
    OP_EMIT_LEAD,
    OP_MUL_COL,
    OP_COL_BASE,
    OP_EMIT_COLOR,
    OP_MUL_USED,
    OP_BORDER_BASE,
    OP_EMIT_BORDER,
    OP_MUL_STEP,
    OP_ROW_ADV,
    OP_EMIT_TAIL
  } iubw_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_LEAD_MUL,
    ST_LEAD_SUM,
    ST_LEAD_EMIT,
    ST_COL_MUL,
    ST_COL_BASE,
    ST_COLOR,
    ST_USED_MUL,
    ST_BORDER_BASE,
    ST_BORDER,
    ST_STEP_MUL,
    ST_ROW_ADV,
    ST_TAIL,
    ST_RELOAD_MUL,
    ST_RELOAD_SUM
  } iubw_state_e;

  typedef struct packed {
    iubw_op_e op;
    logic     last;
    logic     col_inc;
  } iubw_cmd_t;

  typedef struct packed {
    logic out_free;
    logic scale_more;
    logic l_last;
    logic last_col;
    logic last_row;
  } iubw_sts_t;

endpackage

// File: design/iubw_if.sv
// Handshake channel interfaces: source pixels, write runs and configuration writes.
interface iubw_pix_if;
  logic                         valid;
  logic                         ready;
  logic                         start_of_frame;
  logic [iubw_pkg::PIX_W-1:0]   pixel;
  modport source(output valid, start_of_frame, pixel, input ready);
  modport sink(input valid, start_of_frame, pixel, output ready);
endinterface

interface iubw_run_if;
  logic                         valid;
  logic                         ready;
  logic [iubw_pkg::ADDR_W-1:0]  address;
  logic [iubw_pkg::ADDR_W-1:0]  run_length;
  logic [iubw_pkg::PIX_W-1:0]   color;
  logic                         last;
  modport source(output valid, address, run_length, color, last, input ready);
  modport sink(input valid, address, run_length, color, last, output ready);
endinterface

interface iubw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [iubw_pkg::CFG_IDX_W-1:0] index;
  logic [iubw_pkg::DIM_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: design/iubw_ctrl.sv
// Run sequencer: steps the datapath through scale search, run emission and row bookkeeping.
module iubw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_sof_i,
  output logic                in_ready_o,
  input  iubw_pkg::iubw_sts_t sts_i,
  output iubw_pkg::iubw_cmd_t cmd_o
);

  iubw_pkg::iubw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iubw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.op      = iubw_pkg::OP_NOP;
    cmd_o.last    = 1'b0;
    cmd_o.col_inc = 1'b0;
    case (state_q)
      iubw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = iubw_pkg::OP_LOAD;
          state_d  = in_sof_i ? iubw_pkg::ST_SCALE : iubw_pkg::ST_COL_MUL;
        end
      end
      iubw_pkg::ST_SCALE: begin
        if (sts_i.scale_more) begin
          cmd_o.op = iubw_pkg::OP_SCALE_STEP;
        end else begin
          cmd_o.op = iubw_pkg::OP_OFFSET;
          state_d  = iubw_pkg::ST_LEAD_MUL;
        end
      end
      iubw_pkg::ST_LEAD_MUL: begin
        cmd_o.op = iubw_pkg::OP_MUL_LEAD;
        state_d  = iubw_pkg::ST_LEAD_SUM;
      end
      iubw_pkg::ST_LEAD_SUM: begin
        cmd_o.op = iubw_pkg::OP_LEAD_SUM;
        state_d  = iubw_pkg::ST_LEAD_EMIT;
      end
      iubw_pkg::ST_LEAD_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.op = iubw_pkg::OP_EMIT_LEAD;
          state_d  = iubw_pkg::ST_COL_MUL;
        end
      end
      iubw_pkg::ST_COL_MUL: begin
        cmd_o.op = iubw_pkg::OP_MUL_COL;
        state_d  = iubw_pkg::ST_COL_BASE;
      end
      iubw_pkg::ST_COL_BASE: begin
        cmd_o.op = iubw_pkg::OP_COL_BASE;
        state_d  = iubw_pkg::ST_COLOR;
      end
      iubw_pkg::ST_COLOR: begin
        if (sts_i.out_free) begin
          cmd_o.op   = iubw_pkg::OP_EMIT_COLOR;
          cmd_o.last = sts_i.l_last && !sts_i.last_col;
          if (sts_i.l_last) begin
            cmd_o.col_inc = !sts_i.last_col;
            state_d       = sts_i.last_col ? iubw_pkg::ST_USED_MUL : iubw_pkg::ST_IDLE;
          end
        end
      end
      iubw_pkg::ST_USED_MUL: begin
        cmd_o.op = iubw_pkg::OP_MUL_USED;
        state_d  = iubw_pkg::ST_BORDER_BASE;
      end
      iubw_pkg::ST_BORDER_BASE: begin
        cmd_o.op = iubw_pkg::OP_BORDER_BASE;
        state_d  = iubw_pkg::ST_BORDER;
      end
      iubw_pkg::ST_BORDER: begin
        if (sts_i.out_free) begin
          cmd_o.op   = iubw_pkg::OP_EMIT_BORDER;
          cmd_o.last = sts_i.l_last && !sts_i.last_row;
          if (sts_i.l_last) begin
            state_d = iubw_pkg::ST_STEP_MUL;
          end
        end
      end
      iubw_pkg::ST_STEP_MUL: begin
        cmd_o.op = iubw_pkg::OP_MUL_STEP;
        state_d  = iubw_pkg::ST_ROW_ADV;
      end
      iubw_pkg::ST_ROW_ADV: begin
        cmd_o.op = iubw_pkg::OP_ROW_ADV;
        state_d  = sts_i.last_row ? iubw_pkg::ST_TAIL : iubw_pkg::ST_IDLE;
      end
      iubw_pkg::ST_TAIL: begin
        if (sts_i.out_free) begin
          cmd_o.op   = iubw_pkg::OP_EMIT_TAIL;
          cmd_o.last = 1'b1;
          state_d    = iubw_pkg::ST_RELOAD_MUL;
        end
      end
      // The row base returns to the frame origin before the next pixel is taken.
      iubw_pkg::ST_RELOAD_MUL: begin
        cmd_o.op = iubw_pkg::OP_MUL_LEAD;
        state_d  = iubw_pkg::ST_RELOAD_SUM;
      end
      iubw_pkg::ST_RELOAD_SUM: begin
        cmd_o.op = iubw_pkg::OP_LEAD_SUM;
        state_d  = iubw_pkg::ST_IDLE;
      end
      default: begin
        state_d = iubw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/iubw_dp.sv
// Datapath: configuration registers, position state, shared multiplier, run clipping and output register.
module iubw_dp #(
  parameter int MAX_SCALE = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  iubw_pkg::iubw_cmd_t              cmd_i,
  output iubw_pkg::iubw_sts_t              sts_o,
  input  logic                             cfg_valid_i,
  input  logic [iubw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [iubw_pkg::DIM_W-1:0]       cfg_data_i,
  input  logic [iubw_pkg::PIX_W-1:0]       pixel_i,
  output logic                             run_valid_o,
  input  logic                             run_ready_i,
  output logic [iubw_pkg::ADDR_W-1:0]      address_o,
  output logic [iubw_pkg::ADDR_W-1:0]      run_length_o,
  output logic [iubw_pkg::PIX_W-1:0]       color_o,
  output logic                             last_o
);

  localparam int DimW   = iubw_pkg::DIM_W;
  localparam int AddrW  = iubw_pkg::ADDR_W;
  localparam int PixW   = iubw_pkg::PIX_W;
  localparam int MulW   = iubw_pkg::MUL_W;
  localparam int AExtW  = iubw_pkg::AEXT_W;
  localparam int ScaleW = $clog2(MAX_SCALE + 1);
  localparam int AccW   = DimW + ScaleW + 1;

  function automatic logic [DimW-1:0] dim_fix(input logic [DimW-1:0] v);
    return (v == '0) ? DimW'(1) : v;
  endfunction

  // Configuration registers.
  logic [DimW-1:0] dest_width_q, dest_height_q, src_width_q, src_height_q;
  logic            pixel_format_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_width_q   <= iubw_pkg::RST_DEST_WIDTH;
      dest_height_q  <= iubw_pkg::RST_DEST_HEIGHT;
      src_width_q    <= iubw_pkg::RST_SRC_WIDTH;
      src_height_q   <= iubw_pkg::RST_SRC_HEIGHT;
      pixel_format_q <= iubw_pkg::FMT_RGB565;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        iubw_pkg::CFG_DEST_WIDTH:   dest_width_q   <= cfg_data_i;
        iubw_pkg::CFG_DEST_HEIGHT:  dest_height_q  <= cfg_data_i;
        iubw_pkg::CFG_SRC_WIDTH:    src_width_q    <= cfg_data_i;
        iubw_pkg::CFG_SRC_HEIGHT:   src_height_q   <= cfg_data_i;
        iubw_pkg::CFG_PIXEL_FORMAT: pixel_format_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Live sizes: zero reads as one, and the source is clipped to the destination.
  logic [DimW-1:0] dw, dh, sw, sh, wc, hc;
  assign dw = dim_fix(dest_width_q);
  assign dh = dim_fix(dest_height_q);
  assign sw = dim_fix(src_width_q);
  assign sh = dim_fix(src_height_q);
  assign wc = (sw > dw) ? dw : sw;
  assign hc = (sh > dh) ? dh : sh;

  // Buffer size in words, tracked from the live registers.
  logic [MulW-1:0]  area;
  logic [AddrW-1:0] end_q;
  assign area = MulW'(dw) * MulW'(dh);

  always_ff @(posedge clk_i) begin
    end_q <= AddrW'(area);
  end

  // Frame state.
  logic [DimW-1:0]   col_q, col_d, row_q, row_d;
  logic [ScaleW-1:0] scale_q, scale_d;
  logic [DimW-1:0]   offx_q, offx_d, offy_q, offy_d;
  logic [AddrW-1:0]  row_base_q, row_base_d;

  // Per item working registers.
  logic [ScaleW-1:0] k_q, k_d, l_q, l_d;
  logic [AccW-1:0]   accw_q, accw_d, acch_q, acch_d;
  logic [AExtW-1:0]  acc_q, acc_d;
  logic [DimW-1:0]   gap_q, gap_d;
  logic [PixW-1:0]   pix_color_q, pix_color_d;
  logic [MulW-1:0]   mul_q, mul_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [AddrW-1:0]  out_addr_q, out_addr_d, out_len_q, out_len_d;
  logic [PixW-1:0]   out_color_q, out_color_d;
  logic              out_last_q, out_last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      scale_q     <= ScaleW'(1);
      offx_q      <= '0;
      offy_q      <= '0;
      row_base_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      scale_q     <= scale_d;
      offx_q      <= offx_d;
      offy_q      <= offy_d;
      row_base_q  <= row_base_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    l_q         <= l_d;
    accw_q      <= accw_d;
    acch_q      <= acch_d;
    acc_q       <= acc_d;
    gap_q       <= gap_d;
    pix_color_q <= pix_color_d;
    mul_q       <= mul_d;
    out_addr_q  <= out_addr_d;
    out_len_q   <= out_len_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  // Status toward the sequencer.
  logic [DimW:0]     col_nx, row_nx;
  logic [DimW-1:0]   s_ext;
  logic              fits, last_col, last_row;
  assign col_nx   = {1'b0, col_q} + (DimW + 1)'(1);
  assign row_nx   = {1'b0, row_q} + (DimW + 1)'(1);
  assign last_col = col_nx >= {1'b0, wc};
  assign last_row = row_nx >= {1'b0, hc};
  assign s_ext    = {{(DimW - ScaleW){1'b0}}, scale_q};
  // The factor grows while it is below MAX_SCALE and one more step still fits both axes.
  assign fits     = (k_q < ScaleW'(MAX_SCALE)) &&
                    ((accw_q + AccW'(wc)) <= AccW'(dw)) &&
                    ((acch_q + AccW'(hc)) <= AccW'(dh));

  assign sts_o.out_free   = !out_valid_q || run_ready_i;
  assign sts_o.scale_more = fits;
  assign sts_o.l_last     = (l_q == (scale_q - ScaleW'(1)));
  assign sts_o.last_col   = last_col;
  assign sts_o.last_row   = last_row;

  // Shared multiplier.
  logic [DimW-1:0] mul_a, mul_b;
  logic            mul_en;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = dw;
    mul_b  = s_ext;
    case (cmd_i.op)
      iubw_pkg::OP_MUL_LEAD: begin
        mul_a = dw;
        mul_b = offy_q;
      end
      iubw_pkg::OP_MUL_COL: begin
        mul_a = col_q;
        mul_b = s_ext;
      end
      iubw_pkg::OP_MUL_USED: begin
        mul_a = wc;
        mul_b = s_ext;
      end
      iubw_pkg::OP_MUL_STEP: begin
        mul_a = dw;
        mul_b = s_ext;
      end
      default: mul_en = 1'b0;
    endcase
    mul_d = mul_en ? (MulW'(mul_a) * MulW'(mul_b)) : mul_q;
  end

  // Run selection and clipping against the end of the buffer.
  logic [AExtW-1:0] em_addr;
  logic [AddrW-1:0] em_len, em_rem, em_len_c;
  logic [PixW-1:0]  em_color;
  logic             emit;

  always_comb begin
    emit     = 1'b1;
    em_addr  = acc_q;
    em_len   = '0;
    em_color = '0;
    case (cmd_i.op)
      iubw_pkg::OP_EMIT_LEAD: begin
        em_addr = '0;
        em_len  = row_base_q;
      end
      iubw_pkg::OP_EMIT_COLOR: begin
        em_len   = AddrW'(scale_q);
        em_color = pix_color_q;
      end
      iubw_pkg::OP_EMIT_BORDER: begin
        em_len = AddrW'(gap_q);
      end
      iubw_pkg::OP_EMIT_TAIL: begin
        em_addr = AExtW'(row_base_q);
        em_len  = end_q;
      end
      default: emit = 1'b0;
    endcase
    em_rem = end_q - em_addr[AddrW-1:0];
    if (em_addr >= AExtW'(end_q)) begin
      em_len_c = '0;
    end else begin
      em_len_c = (em_len > em_rem) ? em_rem : em_len;
    end
  end

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    scale_d     = scale_q;
    offx_d      = offx_q;
    offy_d      = offy_q;
    row_base_d  = row_base_q;
    k_d         = k_q;
    l_d         = l_q;
    accw_d      = accw_q;
    acch_d      = acch_q;
    acc_d       = acc_q;
    gap_d       = gap_q;
    pix_color_d = pix_color_q;
    case (cmd_i.op)
      iubw_pkg::OP_LOAD: begin
        if (pixel_format_q == iubw_pkg::FMT_RGB565) begin
          pix_color_d = {8'h00, pixel_i[15:11], 3'b000, pixel_i[10:5], 2'b00,
                         pixel_i[4:0], 3'b000};
        end else begin
          pix_color_d = pixel_i;
        end
        k_d    = ScaleW'(1);
        accw_d = AccW'(wc);
        acch_d = AccW'(hc);
      end
      iubw_pkg::OP_SCALE_STEP: begin
        k_d    = k_q + ScaleW'(1);
        accw_d = accw_q + AccW'(wc);
        acch_d = acch_q + AccW'(hc);
      end
      iubw_pkg::OP_OFFSET: begin
        scale_d = k_q;
        offx_d  = DimW'((AccW'(dw) - accw_q) >> 1);
        offy_d  = DimW'((AccW'(dh) - acch_q) >> 1);
        col_d   = '0;
        row_d   = '0;
      end
      iubw_pkg::OP_LEAD_SUM: begin
        row_base_d = AddrW'(mul_q) + AddrW'(offx_q);
      end
      iubw_pkg::OP_COL_BASE: begin
        acc_d = AExtW'(row_base_q) + AExtW'(mul_q);
        l_d   = '0;
      end
      iubw_pkg::OP_EMIT_COLOR: begin
        acc_d = acc_q + AExtW'(dw);
        l_d   = l_q + ScaleW'(1);
        if (cmd_i.col_inc) begin
          col_d = col_q + DimW'(1);
        end
      end
      iubw_pkg::OP_BORDER_BASE: begin
        acc_d = AExtW'(row_base_q) + AExtW'(mul_q);
        gap_d = (MulW'(dw) > mul_q) ? DimW'(MulW'(dw) - mul_q) : '0;
        l_d   = '0;
      end
      iubw_pkg::OP_EMIT_BORDER: begin
        acc_d = acc_q + AExtW'(dw);
        l_d   = l_q + ScaleW'(1);
      end
      iubw_pkg::OP_ROW_ADV: begin
        row_base_d = row_base_q + AddrW'(mul_q);
        col_d      = '0;
        row_d      = last_row ? '0 : row_q + DimW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_len_d   = out_len_q;
    out_color_d = out_color_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_addr_d  = em_addr[AddrW-1:0];
      out_len_d   = em_len_c;
      out_color_d = em_color;
      out_last_d  = cmd_i.last;
    end else if (run_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign run_valid_o  = out_valid_q;
  assign address_o    = out_addr_q;
  assign run_length_o = out_len_q;
  assign color_o      = out_color_q;
  assign last_o       = out_last_q;

endmodule

// File: design/integer_upscale_blit_writer.sv
// Top level of the integer upscale blit writer: sequencer, datapath and channel wiring.
//
// Each source pixel item, in raster order, produces framebuffer write runs for a frame scaled
// by a whole factor s (at most MAX_SCALE) and centered in the destination; every uncovered word
// is written black, and each run is clipped to the end of the buffer. The runs of a group leave
// one per cycle while the output is free, through a single output register, so an item is
// accepted while its last run still waits. A pixel inside a row emits its s color runs; the
// last pixel of a row adds the border runs; the last pixel of a frame adds the tail run and the
// return to the frame origin; a start of frame adds the factor search and the leading run. The
// run sequencer steps these through one shared 12 x 12 multiplier, and a stall on the output
// side holds it until the output register is free. Configuration writes are always taken.
module integer_upscale_blit_writer #(
  parameter int MAX_SCALE = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  iubw_pix_if.sink          pix_i,
  iubw_run_if.source        run_o,
  iubw_cfg_if.sink          cfg_i
);

  iubw_pkg::iubw_cmd_t cmd;
  iubw_pkg::iubw_sts_t sts;

  assign cfg_i.ready = 1'b1;

  iubw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_sof_i   (pix_i.start_of_frame),
    .in_ready_o (pix_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iubw_dp #(
    .MAX_SCALE (MAX_SCALE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .pixel_i      (pix_i.pixel),
    .run_valid_o  (run_o.valid),
    .run_ready_i  (run_o.ready),
    .address_o    (run_o.address),
    .run_length_o (run_o.run_length),
    .color_o      (run_o.color),
    .last_o       (run_o.last)
  );

endmodule

// File: tb/sv/integer_upscale_blit_writer_test.sv
// Self-checking testbench for the integer upscale blit writer: predicted runs vs. RTL runs.
`timescale 1ns / 100ps

module integer_upscale_blit_writer_test;

  localparam int DIM_W      = iubw_pkg::DIM_W;
  localparam int ADDR_W     = iubw_pkg::ADDR_W;
  localparam int PIX_W      = iubw_pkg::PIX_W;
  localparam int CFG_IDX_W  = iubw_pkg::CFG_IDX_W;
  localparam int MAX_SCALE  = 10;
  localparam int ITEM_COUNT = 360;
  localparam int IDLE_LIMIT = 2000;
  localparam int END_PAUSE  = 40;
  // Not a register of the block; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct {
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] run_length;
    logic [PIX_W-1:0]  color;
    logic              last;
  } write_run_t;

  class blit_run_scoreboard;
    logic [DIM_W-1:0]  dest_w, dest_h, src_w, src_h;
    logic              fmt;
    logic [DIM_W-1:0]  col, row, off_x, off_y;
    int unsigned       scale;
    logic [ADDR_W-1:0] row_base;
    write_run_t        expected_runs[$];
    int                mismatches;

    function new();
      dest_w     = iubw_pkg::RST_DEST_WIDTH;
      dest_h     = iubw_pkg::RST_DEST_HEIGHT;
      src_w      = iubw_pkg::RST_SRC_WIDTH;
      src_h      = iubw_pkg::RST_SRC_HEIGHT;
      fmt        = iubw_pkg::FMT_RGB565;
      col        = '0;
      row        = '0;
      off_x      = '0;
      off_y      = '0;
      scale      = 1;
      row_base   = '0;
      mismatches = 0;
    endfunction

    // A size register holding zero behaves as one.
    function int unsigned eff_dim(logic [DIM_W-1:0] v);
      return (v == '0) ? 1 : int'(v);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      case (idx)
        iubw_pkg::CFG_DEST_WIDTH:   dest_w = val;
        iubw_pkg::CFG_DEST_HEIGHT:  dest_h = val;
        iubw_pkg::CFG_SRC_WIDTH:    src_w = val;
        iubw_pkg::CFG_SRC_HEIGHT:   src_h = val;
        iubw_pkg::CFG_PIXEL_FORMAT: fmt = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned frame_pixels();
      int unsigned dw, dh, sw, sh;
      dw = eff_dim(dest_w);
      dh = eff_dim(dest_h);
      sw = eff_dim(src_w);
      sh = eff_dim(src_h);
      if (sw > dw) sw = dw;
      if (sh > dh) sh = dh;
      return sw * sh;
    endfunction

    // Every run is clipped so that it does not run past the buffer end.
    function void add_run(int unsigned addr, int unsigned len, logic [PIX_W-1:0] color,
                          int unsigned buf_end);
      write_run_t r;
      if (addr >= buf_end) len = 0;
      else if (len > buf_end - addr) len = buf_end - addr;
      r.address    = ADDR_W'(addr);
      r.run_length = ADDR_W'(len);
      r.color      = color;
      r.last       = 1'b0;
      expected_runs.push_back(r);
    endfunction

    function void predict_runs(logic sof, logic [PIX_W-1:0] px);
      int unsigned dw, dh, sw, sh, sc, lead, used, gap, buf_end, base;
      logic [PIX_W-1:0] color;
      write_run_t tail;
      dw = eff_dim(dest_w);
      dh = eff_dim(dest_h);
      sw = eff_dim(src_w);
      sh = eff_dim(src_h);
      if (sw > dw) sw = dw;
      if (sh > dh) sh = dh;
      buf_end = dw * dh;

      if (sof) begin
        sc = dw / sw;
        if (sc > dh / sh) sc = dh / sh;
        if (sc > MAX_SCALE) sc = MAX_SCALE;
        off_x    = DIM_W'((dw - sw * sc) / 2);
        off_y    = DIM_W'((dh - sh * sc) / 2);
        scale    = sc;
        col      = '0;
        row      = '0;
        lead     = int'(off_x) + dw * int'(off_y);
        row_base = ADDR_W'(lead);
        add_run(0, lead, '0, buf_end);
      end

      sc = scale;
      if (fmt == iubw_pkg::FMT_RGB565)
        color = {8'h00, px[15:11], 3'b000, px[10:5], 2'b00, px[4:0], 3'b000};
      else color = px;

      base = int'(row_base);
      for (int unsigned l = 0; l < sc; l++)
        add_run(base + int'(col) * sc + l * dw, sc, color, buf_end);

      if (int'(col) + 1 >= sw) begin
        used = sw * sc;
        gap  = (dw > used) ? dw - used : 0;
        for (int unsigned l = 0; l < sc; l++)
          add_run(base + used + l * dw, gap, '0, buf_end);
        col      = '0;
        row_base = ADDR_W'(base + dw * sc);
        if (int'(row) + 1 >= sh) begin
          base = int'(row_base);
          add_run(base, (buf_end > base) ? buf_end - base : 0, '0, buf_end);
          row      = '0;
          row_base = ADDR_W'(int'(off_x) + dw * int'(off_y));
        end else begin
          row = row + 1'b1;
        end
      end else begin
        col = col + 1'b1;
      end

      tail = expected_runs.pop_back();
      tail.last = 1'b1;
      expected_runs.push_back(tail);
    endfunction

    function void check_run(logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] len,
                            logic [PIX_W-1:0] color, logic last);
      write_run_t want;
      if (expected_runs.size() == 0) begin
        if (mismatches < 10)
          $display("run with nothing pending: addr %h len %h color %h last %b",
                   addr, len, color, last);
        mismatches++;
        return;
      end
      want = expected_runs.pop_front();
      if (want.address !== addr || want.run_length !== len || want.color !== color ||
          want.last !== last) begin
        if (mismatches < 10)
          $display("run mismatch: expected addr %h len %h color %h last %b, got %h %h %h %b",
                   want.address, want.run_length, want.color, want.last,
                   addr, len, color, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_runs.size();
    endfunction

    function bit failed();
      return (mismatches != 0) || (expected_runs.size() != 0);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady;
  int   items_sent;
  int   idle_cycles;
  blit_run_scoreboard blit_sb;

  iubw_pix_if pix();
  iubw_run_if run();
  iubw_cfg_if cfg();

  integer_upscale_blit_writer #(
    .MAX_SCALE(MAX_SCALE)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix),
    .run_o (run),
    .cfg_i (cfg)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Called at a falling edge; leaves cfg.valid high so writes can follow back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    blit_sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic end_cfg();
    cfg.valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic sof, input logic [PIX_W-1:0] px);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix.valid          <= 1'b1;
    pix.start_of_frame <= sof;
    pix.pixel          <= px;
    do @(posedge clk_i); while (!pix.ready);
    blit_sb.predict_runs(sof, px);
    items_sent++;
  endtask

  // Stops the pixel stream and waits for every predicted run; returns at a falling edge.
  task automatic drain_runs();
    @(negedge clk_i);
    pix.valid <= 1'b0;
    while (blit_sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [DIM_W-1:0] pick_dest_dim();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return 12'd1;
      2: return 12'd4095;
      3: return DIM_W'($urandom_range(100, 4095));
      default: return DIM_W'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_src_dim();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return 12'd1;
      2: return 12'd4095;
      default: return DIM_W'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin : run_sink
    int stall;
    run.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      @(negedge clk_i);
      if (stall > 0) begin
        run.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      run.ready <= 1'b1;
      do @(posedge clk_i); while (!run.valid);
      blit_sb.check_run(run.address, run.run_length, run.color, run.last);
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((pix.valid && pix.ready) || (run.valid && run.ready) || (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("integer_upscale_blit_writer test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned frame;
    int n, shape;
    logic sof;
    blit_sb = new();
    items_sent         = 0;
    steady             = 1'b0;
    rst_ni             = 1'b0;
    pix.valid          = 1'b0;
    pix.start_of_frame = 1'b0;
    pix.pixel          = '0;
    cfg.valid          = 1'b0;
    cfg.index          = '0;
    cfg.data           = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Pixels before any start of frame run with the reset scale and no offsets.
    send_pixel(1'b0, '1);
    send_pixel(1'b0, '0);
    send_pixel(1'b1, 32'h0000_f81f);

    // One-pixel buffer, zero source size read as one, copied format.
    drain_runs();
    write_reg(iubw_pkg::CFG_DEST_WIDTH, 12'd1);
    write_reg(iubw_pkg::CFG_DEST_HEIGHT, 12'd1);
    write_reg(iubw_pkg::CFG_SRC_WIDTH, '0);
    write_reg(iubw_pkg::CFG_SRC_HEIGHT, '0);
    write_reg(iubw_pkg::CFG_PIXEL_FORMAT, 12'd1);
    write_reg(CFG_UNUSED, 12'hfff);
    end_cfg();
    send_pixel(1'b1, '1);
    send_pixel(1'b0, 32'h1234_5678);

    // Scale capped at the maximum; the extra pixel wraps back to the frame origin.
    drain_runs();
    write_reg(iubw_pkg::CFG_DEST_WIDTH, 12'd1280);
    write_reg(iubw_pkg::CFG_DEST_HEIGHT, 12'd720);
    write_reg(iubw_pkg::CFG_SRC_WIDTH, 12'd2);
    write_reg(iubw_pkg::CFG_SRC_HEIGHT, 12'd2);
    write_reg(iubw_pkg::CFG_PIXEL_FORMAT, '0);
    end_cfg();
    send_pixel(1'b1, '1);
    send_pixel(1'b0, '0);
    send_pixel(1'b0, 32'hdead_07e0);
    send_pixel(1'b0, 32'h0000_001f);
    send_pixel(1'b0, 32'h5555_aaaa);

    // Largest sizes everywhere.
    drain_runs();
    write_reg(iubw_pkg::CFG_DEST_WIDTH, 12'd4095);
    write_reg(iubw_pkg::CFG_DEST_HEIGHT, 12'd4095);
    write_reg(iubw_pkg::CFG_SRC_WIDTH, 12'd4095);
    write_reg(iubw_pkg::CFG_SRC_HEIGHT, 12'd4095);
    write_reg(iubw_pkg::CFG_PIXEL_FORMAT, 12'd1);
    end_cfg();
    send_pixel(1'b1, '0);
    send_pixel(1'b0, '1);
    send_pixel(1'b0, 32'h8000_0001);

    // Source clipped to a tiny destination: border and tail runs come out empty.
    drain_runs();
    write_reg(iubw_pkg::CFG_DEST_WIDTH, 12'd3);
    write_reg(iubw_pkg::CFG_DEST_HEIGHT, 12'd2);
    end_cfg();
    send_pixel(1'b1, 32'h0102_0304);
    for (int i = 0; i < 5; i++) send_pixel(1'b0, $urandom);

    // Buffer shrunk in the middle of a frame: later runs run past its end.
    drain_runs();
    write_reg(iubw_pkg::CFG_DEST_WIDTH, 12'd20);
    write_reg(iubw_pkg::CFG_DEST_HEIGHT, 12'd20);
    write_reg(iubw_pkg::CFG_SRC_WIDTH, 12'd2);
    write_reg(iubw_pkg::CFG_SRC_HEIGHT, 12'd2);
    write_reg(iubw_pkg::CFG_PIXEL_FORMAT, '0);
    end_cfg();
    send_pixel(1'b1, '1);
    drain_runs();
    write_reg(iubw_pkg::CFG_DEST_HEIGHT, 12'd4);
    end_cfg();
    send_pixel(1'b0, 32'h0000_ffff);
    send_pixel(1'b0, 32'h0000_0841);

    // Source height lowered mid-frame: the current row now ends the frame.
    drain_runs();
    write_reg(iubw_pkg::CFG_SRC_HEIGHT, 12'd1);
    end_cfg();
    send_pixel(1'b0, 32'h0000_7bef);
    send_pixel(1'b0, '1);

    while (items_sent < ITEM_COUNT) begin
      drain_runs();
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) write_reg(iubw_pkg::CFG_DEST_WIDTH, pick_dest_dim());
      if ($urandom_range(0, 1)) write_reg(iubw_pkg::CFG_DEST_HEIGHT, pick_dest_dim());
      if ($urandom_range(0, 1)) write_reg(iubw_pkg::CFG_SRC_WIDTH, pick_src_dim());
      if ($urandom_range(0, 1)) write_reg(iubw_pkg::CFG_SRC_HEIGHT, pick_src_dim());
      if ($urandom_range(0, 1)) write_reg(iubw_pkg::CFG_PIXEL_FORMAT, DIM_W'($urandom));
      end_cfg();

      frame = blit_sb.frame_pixels();
      shape = $urandom_range(0, 9);
      // Mostly whole frames; then overruns, partial frames, headless streams and noise.
      case (shape)
        6:       n = int'(frame) + $urandom_range(1, 5);
        7:       n = $urandom_range(1, int'(frame));
        8:       n = $urandom_range(1, 6);
        9:       n = $urandom_range(1, 10);
        default: n = int'(frame) * $urandom_range(1, 2);
      endcase
      if (n > 60) n = $urandom_range(1, 8);

      for (int i = 0; i < n; i++) begin
        case (shape)
          8:       sof = 1'b0;
          9:       sof = ($urandom_range(0, 2) == 0);
          default: sof = ((i % int'(frame)) == 0);
        endcase
        send_pixel(sof, pick_pixel());
      end
    end

    drain_runs();
    repeat (END_PAUSE) @(posedge clk_i);
    if (blit_sb.failed()) begin
      $display("integer_upscale_blit_writer test failed");
    end else begin
      $display("integer_upscale_blit_writer test passed");
    end
    $finish;
  end

endmodule

// File: files.f
design/iubw_pkg.sv
design/iubw_if.sv
design/iubw_ctrl.sv
design/iubw_dp.sv
design/integer_upscale_blit_writer.sv
tb/sv/integer_upscale_blit_writer_test.sv
